/* hw/rtl/tpbd_pkg.sv */
// ----------------------------------------------------------------------------
// Touch pad baseline and detect: shared types and constants
// State encodings, field codes, register map and reset values used by the
// top level and the trimmed-mean unit.
// ----------------------------------------------------------------------------
package tpbd_pkg;

	// Configuration port geometry.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_REPEAT_MODE    = 2'd0;
	localparam logic [1:0] REG_GATE_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_MAX_COUNT      = 2'd2;

	// Register reset values.
	localparam logic        RST_REPEAT_MODE    = 1'b0;
	localparam logic [15:0] RST_GATE_THRESHOLD = 16'd100;
	localparam logic [15:0] RST_MAX_COUNT      = 16'hFFFF;

	// Input and result codes.
	localparam logic ACTION_CAL  = 1'b0;
	localparam logic ACTION_SCAN = 1'b1;
	localparam logic KIND_CAL    = 1'b0;
	localparam logic KIND_SCAN   = 1'b1;

	// Scan lengths and lockout reload.
	localparam logic [2:0] SCAN_NORMAL  = 3'd3;
	localparam logic [2:0] SCAN_REPEAT  = 3'd6;
	localparam logic [1:0] LOCKOUT_LOAD = 2'd3;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_CALC,
		TS_EMIT
	} tpbd_top_state_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_PIVOT,
		CS_CMP,
		CS_ACCUM,
		CS_DIV
	} tpbd_calc_state_t;

endpackage

/* hw/rtl/tpbd_trim_mean.sv */
// ----------------------------------------------------------------------------
// Touch pad trimmed-mean unit
// Holds the calibration buffer and, on start, ranks every entry against all
// others with one comparator, sums the entries whose rank lies inside the
// trim window and divides the sum by the kept count with a single multiply
// by its rounded-up reciprocal.
// ----------------------------------------------------------------------------
module tpbd_trim_mean #(
	parameter int CAL_SAMPLES   = 10,
	parameter int TRIM_EACH_END = 2,
	parameter int SAMPLE_W      = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [$clog2(CAL_SAMPLES)-1:0]     wr_addr,
	input  logic [SAMPLE_W-1:0]                wr_data,
	input  logic                               start,
	output logic                               done,
	output logic [SAMPLE_W-1:0]                mean
);
	import tpbd_pkg::*;

	localparam int AW       = $clog2(CAL_SAMPLES);
	localparam int KW       = $clog2(CAL_SAMPLES + 1);
	localparam int TRIM_EFF = (2 * TRIM_EACH_END >= CAL_SAMPLES) ?
		(CAL_SAMPLES - 1) / 2 : TRIM_EACH_END;
	localparam int KEPT     = CAL_SAMPLES - 2 * TRIM_EFF;
	localparam int SUM_W    = SAMPLE_W + $clog2(CAL_SAMPLES);
	localparam int RL       = $clog2(KEPT);
	localparam int MW       = SUM_W + 2;
	localparam int PW       = SUM_W + MW;
	// With RL bits of extra precision the rounded-up reciprocal leaves an error
	// below one part in KEPT, so the truncated product is the exact quotient for
	// every sum that fits in SUM_W bits.
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << (SUM_W + RL)) +
		64'(KEPT) - 64'd1) / 64'(KEPT));

	logic [SAMPLE_W-1:0] mem [CAL_SAMPLES];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [AW-1:0]       rd_addr;

	tpbd_calc_state_t    state_q, state_nx;
	logic [AW-1:0]       pivot_idx_q;
	logic [KW-1:0]       cmp_cnt_q;
	logic [SAMPLE_W-1:0] pivot_q;
	logic [AW-1:0]       rank_q;
	logic [SUM_W-1:0]    sum_q;
	logic                done_q;

	logic                cmp_last;
	logic                pivot_last;
	logic                below;
	logic                in_window;
	logic [PW-1:0]       prod;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign cmp_last   = (cmp_cnt_q == KW'(CAL_SAMPLES));
	assign pivot_last = (pivot_idx_q == AW'(CAL_SAMPLES - 1));

	// Stable ordering: equal values rank by buffer position, so the ranks form
	// a permutation. cmp_cnt_q is one ahead of the compared entry's index.
	assign below = (rd_data_q < pivot_q) ||
		((rd_data_q == pivot_q) && (KW'(pivot_idx_q) >= cmp_cnt_q));

	assign in_window = (rank_q >= AW'(TRIM_EFF)) &&
		(rank_q <= AW'(CAL_SAMPLES - 1 - TRIM_EFF));

	assign prod = PW'(sum_q) * PW'(RECIP);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_nx = CS_PIVOT;
				end
			end
			CS_PIVOT: state_nx = CS_CMP;
			CS_CMP: begin
				if (cmp_last) begin
					state_nx = CS_ACCUM;
				end
			end
			CS_ACCUM: state_nx = pivot_last ? CS_DIV : CS_PIVOT;
			CS_DIV:   state_nx = CS_IDLE;
			default:  state_nx = CS_IDLE;
		endcase
	end

	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			CS_PIVOT: rd_addr = pivot_idx_q;
			CS_CMP:   rd_addr = cmp_last ? '0 : cmp_cnt_q[AW-1:0];
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == CS_DIV);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_IDLE: begin
				pivot_idx_q <= '0;
				sum_q       <= '0;
			end
			CS_PIVOT: begin
				cmp_cnt_q <= '0;
				rank_q    <= '0;
			end
			CS_CMP: begin
				if (cmp_cnt_q == '0) begin
					pivot_q <= rd_data_q;
				end else if (below) begin
					rank_q <= rank_q + AW'(1);
				end
				if (!cmp_last) begin
					cmp_cnt_q <= cmp_cnt_q + KW'(1);
				end
			end
			CS_ACCUM: begin
				if (in_window) begin
					sum_q <= sum_q + SUM_W'(pivot_q);
				end
				pivot_idx_q <= pivot_idx_q + AW'(1);
			end
			CS_DIV: begin
				sum_q <= SUM_W'(prod >> (SUM_W + RL));
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	assign done = done_q;
	assign mean = sum_q[SAMPLE_W-1:0];

endmodule

/* hw/rtl/touch_pad_baseline_and_detect_unit.sv */
// ----------------------------------------------------------------------------
// Touch pad baseline and detect unit
// Calibrates a pad baseline from a trimmed mean of charge-time words and
// detects presses by comparing the peak of each scan with baseline plus gate.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_stall    action, charge_count
//  out      source     out_valid / out_stall  result_kind, pressed,
//                                             baseline_value, cal_error
//  cfg      APB slave  psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// A word that completes no calibration or scan leaves the unit idle; a completed
// scan passes through the emit state. The last calibration word starts the
// trimmed-mean walk, in which a single comparator ranks each buffer entry.
// in_stall is high whenever the unit is not idle. A finished result waits in
// its state until the output register is free, so out_stall only delays it.
// Reset clears all control state and the register file to its reset values.
// ----------------------------------------------------------------------------
module touch_pad_baseline_and_detect_unit #(
	parameter int CAL_SAMPLES   = 10,
	parameter int TRIM_EACH_END = 2,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [15:0]                    charge_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic                           pressed,
	output logic [15:0]                    baseline_value,
	output logic                           cal_error,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tpbd_pkg::PADDR_W-1:0]   paddr,
	input  logic [tpbd_pkg::PDATA_W-1:0]   pwdata,
	output logic [tpbd_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import tpbd_pkg::*;

	localparam int SW = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
	localparam int AW = $clog2(CAL_SAMPLES);

	// Register file.
	logic        repeat_mode_q;
	logic [15:0] gate_threshold_q;
	logic [15:0] max_count_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	tpbd_top_state_t state_q, state_nx;
	logic [SW-1:0]   baseline_q;
	logic [AW-1:0]   cal_index_q;
	logic [SW-1:0]   scan_max_q;
	logic [2:0]      scan_index_q;
	logic [1:0]      lockout_q;
	logic            kind_q;
	logic            pend_pressed_q;

	logic            out_valid_q;
	logic            out_kind_q;
	logic            out_pressed_q;
	logic [15:0]     out_baseline_q;
	logic            out_cal_error_q;

	logic            in_acc;
	logic            cal_acc;
	logic            scan_acc;
	logic            cal_last;
	logic            calc_start;
	logic            calc_done;
	logic [SW-1:0]   calc_mean;
	logic            emit_fire;
	logic [SW-1:0]   sample;
	logic [2:0]      scan_needed;
	logic [2:0]      scan_idx_nx;
	logic [SW-1:0]   scan_max_nx;
	logic            scan_done;
	logic [1:0]      lock_cur;
	logic [1:0]      lock_hit;
	logic [1:0]      lock_nx;
	logic            over_gate;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_mode_q    <= RST_REPEAT_MODE;
			gate_threshold_q <= RST_GATE_THRESHOLD;
			max_count_q      <= RST_MAX_COUNT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_REPEAT_MODE:    repeat_mode_q    <= pwdata[0];
				REG_GATE_THRESHOLD: gate_threshold_q <= pwdata[15:0];
				REG_MAX_COUNT:      max_count_q      <= pwdata[15:0];
				default:            repeat_mode_q    <= repeat_mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_REPEAT_MODE:    prdata = PDATA_W'(repeat_mode_q);
			REG_GATE_THRESHOLD: prdata = PDATA_W'(gate_threshold_q);
			REG_MAX_COUNT:      prdata = PDATA_W'(max_count_q);
			default:            prdata = '0;
		endcase
	end

	assign in_acc   = in_valid && !in_stall;
	assign cal_acc  = in_acc && (action == ACTION_CAL);
	assign scan_acc = in_acc && (action == ACTION_SCAN);
	assign sample   = charge_count[SW-1:0];
	assign cal_last = (cal_index_q == AW'(CAL_SAMPLES - 1));

	// Scan datapath: running peak, gate compare kept one bit wider.
	assign scan_needed = repeat_mode_q ? SCAN_REPEAT : SCAN_NORMAL;
	assign scan_idx_nx = scan_index_q + 3'd1;
	assign scan_max_nx = (sample > scan_max_q) ? sample : scan_max_q;
	assign scan_done   = (scan_idx_nx >= scan_needed);
	assign over_gate   = 17'(scan_max_nx) > (17'(baseline_q) + 17'(gate_threshold_q));
	assign lock_cur    = repeat_mode_q ? 2'd0 : lockout_q;
	assign lock_hit    = over_gate ? LOCKOUT_LOAD : lock_cur;
	assign lock_nx     = (lock_hit != 2'd0) ? lock_hit - 2'd1 : 2'd0;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			TS_IDLE: begin
				if (cal_acc && cal_last) begin
					state_nx = TS_CALC;
				end else if (scan_acc && scan_done) begin
					state_nx = TS_EMIT;
				end
			end
			TS_CALC: begin
				if (calc_done) begin
					state_nx = TS_EMIT;
				end
			end
			TS_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					state_nx = TS_IDLE;
				end
			end
			default: state_nx = TS_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		calc_start = 1'b0;
		emit_fire  = 1'b0;
		unique case (state_q)
			TS_IDLE: begin
				in_stall   = 1'b0;
				calc_start = cal_acc && cal_last;
			end
			TS_EMIT: emit_fire = !out_valid_q || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	tpbd_trim_mean #(
		.CAL_SAMPLES   (CAL_SAMPLES),
		.TRIM_EACH_END (TRIM_EACH_END),
		.SAMPLE_W      (SW)
	) u_trim_mean (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cal_acc),
		.wr_addr (cal_index_q),
		.wr_data (sample),
		.start   (calc_start),
		.done    (calc_done),
		.mean    (calc_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= TS_IDLE;
			baseline_q   <= '0;
			cal_index_q  <= '0;
			scan_max_q   <= '0;
			scan_index_q <= '0;
			lockout_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cal_acc) begin
				cal_index_q <= cal_last ? '0 : cal_index_q + AW'(1);
			end
			if (scan_acc) begin
				if (scan_done) begin
					scan_max_q   <= '0;
					scan_index_q <= '0;
					lockout_q    <= lock_nx;
				end else begin
					scan_max_q   <= scan_max_nx;
					scan_index_q <= scan_idx_nx;
				end
			end
			if (calc_done) begin
				baseline_q <= calc_mean;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cal_acc) begin
			kind_q <= KIND_CAL;
		end else if (scan_acc) begin
			kind_q         <= KIND_SCAN;
			pend_pressed_q <= over_gate && (lock_cur == 2'd0);
		end
		if (emit_fire) begin
			out_kind_q      <= kind_q;
			out_pressed_q   <= (kind_q == KIND_SCAN) && pend_pressed_q;
			out_baseline_q  <= 16'(baseline_q);
			out_cal_error_q <= (kind_q == KIND_CAL) &&
				(16'(baseline_q) > {1'b0, max_count_q[15:1]});
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign pressed        = out_pressed_q;
	assign baseline_value = out_baseline_q;
	assign cal_error      = out_cal_error_q;

endmodule

/* test/touch_pad_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch pad unit monitor
// Watches the input, result and register ports of the touch pad unit. It keeps
// its own copy of the registers, the calibration buffer and the scan and
// lockout state, works out the result of each calibration or scan that a word
// completes, and compares each result word field by field with the oldest one due.
// ----------------------------------------------------------------------------
module touch_pad_monitor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         action,
	input  logic [15:0]                  charge_count,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         result_kind,
	input  logic                         pressed,
	input  logic [15:0]                  baseline_value,
	input  logic                         cal_error,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [tpbd_pkg::PADDR_W-1:0] paddr,
	input  logic [tpbd_pkg::PDATA_W-1:0] pwdata,
	input  logic [tpbd_pkg::PDATA_W-1:0] prdata,
	output int unsigned                  pending,
	output int unsigned                  errors,
	output int unsigned                  cal_done,
	output int unsigned                  cal_flagged,
	output int unsigned                  scans_done,
	output int unsigned                  presses
);
	import tpbd_pkg::*;

	localparam int CAL_N    = 10;
	localparam int TRIM_END = 2;

	typedef struct packed {
		logic        kind;
		logic        pressed;
		logic [15:0] level;
		logic        cal_error;
	} pad_result_t;

	pad_result_t results_due[$];

	logic [15:0] cal_buf [CAL_N];
	int unsigned cal_fill;
	logic [15:0] base_level;
	logic [15:0] peak;
	logic [2:0]  scan_fill;
	logic [1:0]  lock_left;
	logic        rep_mode;
	logic [15:0] gate;
	logic [15:0] full_scale;
	int unsigned fails = 0;
	int unsigned n_cal = 0;
	int unsigned n_flag = 0;
	int unsigned n_scan = 0;
	int unsigned n_press = 0;

	function automatic logic [15:0] trimmed_mean();
		logic [15:0] ranked [CAL_N];
		logic [15:0] v;
		logic [31:0] acc;
		int i, j, trim;
		ranked = cal_buf;
		for (i = 1; i < CAL_N; i++) begin
			v = ranked[i];
			j = i;
			while (j > 0 && ranked[j-1] > v) begin
				ranked[j] = ranked[j-1];
				j--;
			end
			ranked[j] = v;
		end
		// Never trim the whole buffer away.
		trim = (2 * TRIM_END >= CAL_N) ? (CAL_N - 1) / 2 : TRIM_END;
		acc = '0;
		for (i = trim; i < CAL_N - trim; i++)
			acc += ranked[i];
		return 16'(acc / (CAL_N - 2 * trim));
	endfunction

	task automatic note_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		pad_result_t want;
		logic [2:0] needed;
		logic       hit;
		if (!arst_n) begin
			results_due.delete();
			cal_fill   = 0;
			base_level = '0;
			peak       = '0;
			scan_fill  = '0;
			lock_left  = '0;
			rep_mode   = RST_REPEAT_MODE;
			gate       = RST_GATE_THRESHOLD;
			full_scale = RST_MAX_COUNT;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					fails++;
					$display("%0t ns: unexpected result word, expected nothing, %s %0d %0d",
						$time, "actual kind and baseline", result_kind, baseline_value);
				end else begin
					want = results_due.pop_front();
					note_field("result_kind", 32'(want.kind), 32'(result_kind));
					note_field("pressed", 32'(want.pressed), 32'(pressed));
					note_field("baseline_value", 32'(want.level), 32'(baseline_value));
					note_field("cal_error", 32'(want.cal_error), 32'(cal_error));
				end
			end

			if (in_valid && !in_stall) begin
				if (action == ACTION_CAL) begin
					if (cal_fill >= CAL_N)
						cal_fill = 0;
					cal_buf[cal_fill] = charge_count;
					cal_fill++;
					if (cal_fill == CAL_N) begin
						cal_fill          = 0;
						base_level        = trimmed_mean();
						want.kind         = KIND_CAL;
						want.pressed      = 1'b0;
						want.level        = base_level;
						want.cal_error    = base_level > (full_scale >> 1);
						results_due.push_back(want);
						n_cal++;
						if (want.cal_error)
							n_flag++;
					end
				end else begin
					// The sample count is the one in force when the word arrives, so a
					// mode change part way through a scan takes effect at once.
					needed = rep_mode ? SCAN_REPEAT : SCAN_NORMAL;
					if (charge_count > peak)
						peak = charge_count;
					scan_fill = scan_fill + 3'd1;
					if (scan_fill >= needed) begin
						if (rep_mode)
							lock_left = '0;
						hit = 1'b0;
						if (17'(peak) > 17'(base_level) + 17'(gate)) begin
							hit       = (lock_left == 2'd0);
							lock_left = LOCKOUT_LOAD;
						end
						if (lock_left != 2'd0)
							lock_left--;
						peak         = '0;
						scan_fill    = '0;
						want.kind    = KIND_SCAN;
						want.pressed = hit;
						want.level   = base_level;
						want.cal_error = 1'b0;
						results_due.push_back(want);
						n_scan++;
						if (hit)
							n_press++;
					end
				end
			end

			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[PADDR_W-1:2])
						REG_REPEAT_MODE:    rep_mode   = pwdata[0];
						REG_GATE_THRESHOLD: gate       = pwdata[15:0];
						REG_MAX_COUNT:      full_scale = pwdata[15:0];
						default: ;
					endcase
				end else begin
					case (paddr[PADDR_W-1:2])
						REG_REPEAT_MODE:
							note_field("repeat_mode readback", 32'(rep_mode),
								32'(prdata[0]));
						REG_GATE_THRESHOLD:
							note_field("gate_threshold readback", 32'(gate),
								32'(prdata[15:0]));
						REG_MAX_COUNT:
							note_field("max_count readback", 32'(full_scale),
								32'(prdata[15:0]));
						default: ;
					endcase
				end
			end
		end
		pending     <= results_due.size();
		errors      <= fails;
		cal_done    <= n_cal;
		cal_flagged <= n_flag;
		scans_done  <= n_scan;
		presses     <= n_press;
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch pad unit testbench
// Drives calibration and scan words through the touch pad unit under random
// input gaps and output stalls, moves the registers through several settings
// between phases, and leaves the checking to the monitor beside the unit.
// ----------------------------------------------------------------------------
module tb;
	import tpbd_pkg::*;

	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 50;
	localparam int SETTLE          = 20;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               action       = ACTION_CAL;
	logic [15:0]        charge_count = '0;
	logic               out_stall    = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;

	logic               in_stall;
	logic               out_valid;
	logic               result_kind;
	logic               pressed;
	logic [15:0]        baseline_value;
	logic               cal_error;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned pending, errors, cal_done, cal_flagged, scans_done, presses;
	int unsigned words_sent = 0;
	int unsigned settings_used = 0;
	int unsigned hold_out = 0;
	bit          calm_in = 1'b0;
	bit          calm_out = 1'b0;
	int          pad_level = 0;
	int          gate_now = 100;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	touch_pad_baseline_and_detect_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.charge_count   (charge_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.pressed        (pressed),
		.baseline_value (baseline_value),
		.cal_error      (cal_error),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	touch_pad_monitor pad_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.charge_count   (charge_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.pressed        (pressed),
		.baseline_value (baseline_value),
		.cal_error      (cal_error),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pending        (pending),
		.errors         (errors),
		.cal_done       (cal_done),
		.cal_flagged    (cal_flagged),
		.scans_done     (scans_done),
		.presses        (presses)
	);

	function automatic int unsigned draw_wait(input bit calm);
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [15:0] clamp_count(input int v);
		if (v < 0)
			return 16'h0000;
		if (v > 65535)
			return 16'hFFFF;
		return 16'(v);
	endfunction

	// Scan samples sit mostly around the last calibration level, some near the
	// gate edge, some well above it, and a few anywhere in range.
	function automatic logic [15:0] scan_count();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return clamp_count(pad_level + int'($urandom_range(0, 100)) - 50);
		if (pick < 60)
			return clamp_count(pad_level + gate_now + int'($urandom_range(0, 40)) - 20);
		if (pick < 80)
			return clamp_count(pad_level + gate_now + int'($urandom_range(0, 3000)));
		return 16'($urandom_range(0, 65535));
	endfunction

	// Called at a rising edge; returns at the edge that accepts the word.
	task automatic send_word(input logic act, input logic [15:0] count);
		int unsigned gap;
		gap = draw_wait(calm_in);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		charge_count <= count;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic reg_access(input logic wr, input logic [1:0] idx,
			input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Hold off until every result due has been taken, then let the unit settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			hold_out = draw_wait(calm_out);
			out_stall <= (hold_out != 0);
		end else if (hold_out != 0) begin
			hold_out--;
			out_stall <= (hold_out != 0);
		end
	end

	initial begin : stimulus
		int          ph, k, len, pick, style, centre, spread;
		int unsigned phase_end;
		logic        rep;
		logic [15:0] gate_val, full_val;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first, then a calibration built from the count extremes.
		reg_access(1'b0, REG_REPEAT_MODE, '0);
		reg_access(1'b0, REG_GATE_THRESHOLD, '0);
		reg_access(1'b0, REG_MAX_COUNT, '0);
		send_word(ACTION_CAL, 16'h0000);
		send_word(ACTION_CAL, 16'hFFFF);
		send_word(ACTION_CAL, 16'h8000);
		send_word(ACTION_CAL, 16'h7FFF);
		send_word(ACTION_CAL, 16'h0001);
		send_word(ACTION_CAL, 16'hFFFE);
		send_word(ACTION_CAL, 16'h5555);
		send_word(ACTION_CAL, 16'hAAAA);
		send_word(ACTION_CAL, 16'h0000);
		send_word(ACTION_CAL, 16'hFFFF);
		// A touch, one quiet scan under lockout, then a scan with a calibration word
		// in its middle that touches again while still locked out, and one more such touch.
		send_word(ACTION_SCAN, 16'hFFFF);
		send_word(ACTION_SCAN, 16'h0000);
		send_word(ACTION_SCAN, 16'h0000);
		for (k = 0; k < 3; k++)
			send_word(ACTION_SCAN, 16'h0000);
		send_word(ACTION_SCAN, 16'h8000);
		send_word(ACTION_SCAN, 16'h7FFF);
		send_word(ACTION_CAL, 16'h1234);
		send_word(ACTION_SCAN, 16'hFFFE);
		for (k = 0; k < 3; k++)
			send_word(ACTION_SCAN, 16'hFFFF);
		pad_level = 32767;

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin rep = 1'b0; gate_val = 16'd0;     full_val = 16'hFFFF; end
				1: begin rep = 1'b1; gate_val = 16'hFFFF;  full_val = 16'd0;    end
				2: begin rep = 1'b0; gate_val = 16'hFFFF;  full_val = 16'd1;    end
				3: begin rep = 1'b1; gate_val = 16'd100;   full_val = 16'hFFFF; end
				default: begin
					rep      = 1'($urandom_range(0, 1));
					gate_val = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3000))
					                                       : 16'($urandom_range(0, 65535));
					full_val = 16'($urandom_range(0, 65535));
				end
			endcase
			// Upper bits of each write carry noise that the register must drop.
			reg_access(1'b1, REG_REPEAT_MODE,
				(PDATA_W'($urandom) & ~PDATA_W'(1)) | PDATA_W'(rep));
			reg_access(1'b1, REG_GATE_THRESHOLD, {16'($urandom), gate_val});
			reg_access(1'b1, REG_MAX_COUNT, {16'($urandom), full_val});
			reg_access(1'b0, REG_REPEAT_MODE, '0);
			reg_access(1'b0, REG_GATE_THRESHOLD, '0);
			reg_access(1'b0, REG_MAX_COUNT, '0);
			settings_used++;
			gate_now = int'(gate_val);
			calm_in  = (ph == 2);
			calm_out = (ph == 2) || (ph == 6);

			phase_end = words_sent + WORDS_PER_PHASE;
			while (words_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					style  = $urandom_range(0, 5);
					centre = (style == 0) ? 0 : (style == 1) ? 65535 : $urandom_range(0, 65535);
					spread = (style == 2) ? 65535 : $urandom_range(0, 400);
					pad_level = centre;
					for (k = 0; k < 10; k++) begin
						send_word(ACTION_CAL,
							clamp_count(centre + int'($urandom_range(0, 2 * spread)) - spread));
						if ($urandom_range(0, 9) == 0)
							send_word(ACTION_SCAN, scan_count());
					end
				end else if (pick < 90) begin
					// Mostly whole scans; now and then a partial one left open.
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
					                                  : (rep ? int'(SCAN_REPEAT) : int'(SCAN_NORMAL));
					for (k = 0; k < len; k++)
						send_word(ACTION_SCAN, scan_count());
				end else begin
					send_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
				end
			end
		end

		wait_drained();
		$display("Run covered %0d words under %0d register settings.", words_sent,
			settings_used + 1);
		$display("Calibrations %0d (%0d out of range), scans %0d with %0d presses.",
			cal_done, cal_flagged, scans_done, presses);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Run timed out with %0d results outstanding.", pending);
		$display("tb failed");
		$finish;
	end

endmodule

/* touch_pad_baseline_and_detect_unit.f */
hw/rtl/tpbd_pkg.sv
hw/rtl/tpbd_trim_mean.sv
hw/rtl/touch_pad_baseline_and_detect_unit.sv
test/touch_pad_monitor.sv
test/tb.sv
